/* sv/c2gws_pkg.sv */
// ----------------------------------------------------------------------------
// c2gws_pkg: calendar to GPS week/seconds shared definitions
// Field widths, the epoch year and the cumulative month-start table.
// ----------------------------------------------------------------------------
`default_nettype none

package c2gws_pkg;

  // beat field widths
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SEC_W    = 26;
  localparam int WEEK_W   = 14;
  localparam int WSEC_W   = 40;

  localparam int EPOCH_YEAR = 1980;

  // days before the first of each month, common year
  function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] month);
    logic [8:0] days;
    case (month)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

/* sv/c2gws_if.sv */
// ----------------------------------------------------------------------------
// c2gws_if: calendar to GPS week/seconds channel interfaces
// Valid/ready channels for the date/time beat and the week/seconds beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface c2gws_in_if;
  import c2gws_pkg::*;

  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   year;
  logic [MONTH_W-1:0]  month;
  logic [DAY_W-1:0]    day;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;
  logic [SEC_W-1:0]    second_us;

  modport source (output valid, year, month, day, hour, minute, second_us,
                  input ready);
  modport sink   (input valid, year, month, day, hour, minute, second_us,
                  output ready);
endinterface

interface c2gws_out_if;
  import c2gws_pkg::*;

  logic              valid;
  logic              ready;
  logic              status;
  logic [WEEK_W-1:0] gps_week;
  logic [WSEC_W-1:0] week_second_us;

  modport source (output valid, status, gps_week, week_second_us, input ready);
  modport sink   (input valid, status, gps_week, week_second_us, output ready);
endinterface

`default_nettype wire

/* sv/calendar_to_gps_week_seconds_core.sv */
// Path: an accepted input beat passes the stage 1, 2, 3 and 4 registers in
//   order. Throughput: one beat per cycle unless the output stalls; the four
//   register stages each take one beat per clock when not stalled, and the
//   divide-by-seven reciprocal multiply owns stage three.
// Reset: synchronous, active low; clears every stage valid bit, data unreset.
// ----------------------------------------------------------------------------
// calendar_to_gps_week_seconds_core: Gregorian date/time to GPS week + TOW
// Four-stage pipeline. Day count from 6 Jan 1980 via closed-form leap count,
// constant divides done as reciprocal multiplies, per-stage valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_to_gps_week_seconds_core #(
  parameter int YEAR_SPAN = 256   // supported years: 1980 .. 1980+YEAR_SPAN-1
) (
  input  wire          clk,
  input  wire          rst_n,
  c2gws_in_if.sink     in_ch,
  c2gws_out_if.source  out_ch
);
  import c2gws_pkg::*;

  // floor(x/100) == (x*5243) >> 19 for x < 4096
  localparam logic [12:0] RECIP_100  = 13'd5243;
  // floor(d/7) == (d*1198373) >> 23 for d < 2^20
  localparam logic [20:0] RECIP_7    = 21'd1198373;
  localparam logic [12:0] YEAR_END   = 13'(EPOCH_YEAR + YEAR_SPAN);
  // leaps_upto(1979) plus the epoch day offset of 6
  localparam logic [21:0] DAY_BIAS   = 22'd485;
  localparam logic [36:0] US_PER_HR  = 37'd3600000000;
  localparam logic [31:0] US_PER_MIN = 32'd60000000;
  localparam logic [39:0] US_PER_DAY = 40'd86400000000;

  // --------------------------------------------------------------------------
  // Handshake: each stage loads when empty or when its successor moves on,
  // so bubbles collapse and a stalled output never drops a beat.
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_r || out_ch.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: range check, month table, the three divides by 100 and the
  // time-of-day products.
  // --------------------------------------------------------------------------
  logic [YEAR_W-1:0] nm1;
  logic [24:0]       p_n100;
  logic [22:0]       p_n400;
  logic [24:0]       p_y100;

  logic              err1_nxt;
  logic [11:0]       yo1_nxt;
  logic [9:0]        q4_1_nxt;
  logic [5:0]        q100_1_nxt;
  logic [3:0]        q400_1_nxt;
  logic [5:0]        yq100_1_nxt;
  logic [36:0]       hr_us1_nxt;
  logic [31:0]       min_us1_nxt;

  logic              err1_r;
  logic [11:0]       yo1_r;
  logic [YEAR_W-1:0] year1_r;
  logic [9:0]        q4_1_r;
  logic [5:0]        q100_1_r;
  logic [3:0]        q400_1_r;
  logic [5:0]        yq100_1_r;
  logic [8:0]        mstart1_r;
  logic              mgt2_1_r;
  logic [DAY_W-1:0]  day1_r;
  logic [36:0]       hr_us1_r;
  logic [31:0]       min_us1_r;
  logic [SEC_W-1:0]  sec1_r;

  always_comb begin
    nm1         = in_ch.year - 12'd1;
    p_n100      = 25'(nm1) * 25'(RECIP_100);
    p_n400      = 23'(nm1[11:2]) * 23'(RECIP_100);   // (n/4)/100 == n/400
    p_y100      = 25'(in_ch.year) * 25'(RECIP_100);
    q4_1_nxt    = nm1[11:2];
    q100_1_nxt  = p_n100[24:19];
    q400_1_nxt  = p_n400[22:19];
    yq100_1_nxt = p_y100[24:19];
    yo1_nxt     = in_ch.year - 12'(EPOCH_YEAR);
    err1_nxt    = (in_ch.year < 12'(EPOCH_YEAR)) || ({1'b0, in_ch.year} >= YEAR_END) ||
                  (in_ch.month == 4'd0) || (in_ch.month > 4'd12) || (in_ch.day == 5'd0);
    hr_us1_nxt  = 37'(in_ch.hour) * US_PER_HR;
    min_us1_nxt = 32'(in_ch.minute) * US_PER_MIN;
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      err1_r    <= err1_nxt;
      yo1_r     <= yo1_nxt;
      year1_r   <= in_ch.year;
      q4_1_r    <= q4_1_nxt;
      q100_1_r  <= q100_1_nxt;
      q400_1_r  <= q400_1_nxt;
      yq100_1_r <= yq100_1_nxt;
      mstart1_r <= month_start(in_ch.month);
      mgt2_1_r  <= in_ch.month > 4'd2;
      day1_r    <= in_ch.day;
      hr_us1_r  <= hr_us1_nxt;
      min_us1_r <= min_us1_nxt;
      sec1_r    <= in_ch.second_us;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: days since the epoch (signed 22 bit, negative means before
  // 6 Jan 1980) and time of day in microseconds.
  // --------------------------------------------------------------------------
  logic        is_cent;
  logic        leap;
  logic [21:0] d2_nxt;
  logic [36:0] tod2_nxt;

  logic        err2_r;
  logic [19:0] d2_r;
  logic [36:0] tod2_r;

  always_comb begin
    is_cent  = (12'(yq100_1_r) * 12'd100) == year1_r;
    leap     = (year1_r[1:0] == 2'b00) && (!is_cent || (yq100_1_r[1:0] == 2'b00));
    d2_nxt   = 22'(yo1_r) * 22'd365 + 22'(q4_1_r) - 22'(q100_1_r) + 22'(q400_1_r)
             + 22'(mstart1_r) + 22'(leap && mgt2_1_r) + 22'(day1_r) - DAY_BIAS;
    tod2_nxt = hr_us1_r + 37'(min_us1_r) + 37'(sec1_r);
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      err2_r <= err1_r || d2_nxt[21];
      d2_r   <= d2_nxt[19:0];
      tod2_r <= tod2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: week number by reciprocal multiply.
  // --------------------------------------------------------------------------
  logic [40:0] p_d7;

  logic        err3_r;
  logic [19:0] d3_r;
  logic [17:0] q7_3_r;
  logic [36:0] tod3_r;

  assign p_d7 = 41'(d2_r) * 41'(RECIP_7);

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      err3_r <= err2_r;
      d3_r   <= d2_r;
      q7_3_r <= p_d7[40:23];
      tod3_r <= tod2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4 (output register): day of week, time of week, error zeroing.
  // --------------------------------------------------------------------------
  logic [19:0]       rem_full;
  logic [WSEC_W-1:0] wsec4_nxt;

  logic              status_r;
  logic [WEEK_W-1:0] week_r;
  logic [WSEC_W-1:0] wsec_r;

  always_comb begin
    rem_full  = d3_r - 20'(20'(q7_3_r) * 20'd7);
    wsec4_nxt = 40'(rem_full[2:0]) * US_PER_DAY + 40'(tod3_r);
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      status_r <= err3_r;
      week_r   <= err3_r ? '0 : q7_3_r[WEEK_W-1:0];
      wsec_r   <= err3_r ? '0 : wsec4_nxt;
    end
  end

  assign out_ch.valid          = v4_r;
  assign out_ch.status         = status_r;
  assign out_ch.gps_week       = week_r;
  assign out_ch.week_second_us = wsec_r;

endmodule

`default_nettype wire

/* sv/c2gws_checker.sv */
// ----------------------------------------------------------------------------
// c2gws_checker: port-level checks for the calendar to GPS week/seconds core
// Output hold under stall, error zeroing, backpressure origin, reset state, intake.
// ----------------------------------------------------------------------------
`default_nettype none

module c2gws_checker (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire                        out_status,
  input wire [c2gws_pkg::WEEK_W-1:0] out_gps_week,
  input wire [c2gws_pkg::WSEC_W-1:0] out_week_second_us
);
  import c2gws_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_gps_week) && $stable(out_week_second_us))
    else $error("result beat changed under stall");

  // error beats carry zero payload
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_gps_week == '0 && out_week_second_us == '0)
    else $error("error beat with nonzero payload");

  // input only backs up when the pipe is full behind a stalled output
  a_bp_origin: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // nothing shown right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  // an offered input beat is taken whenever the output stage is empty
  a_in_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_valid |-> in_ready)
    else $error("input refused with empty output");

endmodule

bind calendar_to_gps_week_seconds_core c2gws_checker u_c2gws_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_gps_week       (out_ch.gps_week),
  .out_week_second_us (out_ch.week_second_us)
);

`default_nettype wire

/* verif/gps_week_checker.sv */
// ----------------------------------------------------------------------------
// gps_week_checker: result checker for the calendar to GPS week/seconds core
// Watches both channels. Every accepted date beat is converted to its
// expected week/time-of-week, and every result beat is compared field by
// field with the oldest pending conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module gps_week_checker #(
  parameter int YEAR_SPAN = 256
) (
  input  wire  clk,
  input  wire  rst_n,
  c2gws_in_if  in_ch,
  c2gws_out_if out_ch,
  output int   mismatches,
  output int   awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  import c2gws_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic              status;
    logic [WEEK_W-1:0] week;
    logic [WSEC_W-1:0] tow_us;
  } gps_time_t;

  localparam int unsigned GPS_EPOCH_DOY = 6;   // 6 Jan 1980
  localparam u64_t US_PER_MIN  = 64'd60_000_000;
  localparam u64_t US_PER_HOUR = 64'd3_600_000_000;
  localparam u64_t US_PER_DAY  = 64'd86_400_000_000;

  // days before each month, common year
  localparam int unsigned DAYS_BEFORE [12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  gps_time_t awaited_q[$];
  int        errors = 0;

  function automatic int unsigned leap_years_thru(input int unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic gps_time_t calendar_to_gps(
    input logic [YEAR_W-1:0]   year,
    input logic [MONTH_W-1:0]  month,
    input logic [DAY_W-1:0]    day,
    input logic [HOUR_W-1:0]   hour,
    input logic [MINUTE_W-1:0] minute,
    input logic [SEC_W-1:0]    second_us
  );
    gps_time_t   r;
    int unsigned y;
    int unsigned days;
    u64_t        tow;
    r        = '0;
    r.status = 1'b1;
    y        = year;
    if (y < EPOCH_YEAR || y >= EPOCH_YEAR + YEAR_SPAN) return r;
    if (month < 1 || month > 12 || day == 0) return r;
    days = 365 * (y - EPOCH_YEAR)
         + leap_years_thru(y - 1) - leap_years_thru(EPOCH_YEAR - 1);
    days += DAYS_BEFORE[int'(month) - 1];
    if (month > 2 && leap_year(y)) days += 1;
    days += day;
    // first five days of 1980 lie before the epoch
    if (days < GPS_EPOCH_DOY) return r;
    days -= GPS_EPOCH_DOY;
    tow = u64_t'(days % 7) * US_PER_DAY + u64_t'(hour) * US_PER_HOUR
        + u64_t'(minute) * US_PER_MIN + u64_t'(second_us);
    r.status = 1'b0;
    r.week   = WEEK_W'(days / 7);
    r.tow_us = WSEC_W'(tow);
    return r;
  endfunction

  function automatic void compare_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    gps_time_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_q.size() == 0) begin
          $display("%0t ns: unexpected result beat, expected none, actual %0d/%0d/%0d",
                   $time, out_ch.status, out_ch.gps_week, out_ch.week_second_us);
          errors++;
        end else begin
          want = awaited_q.pop_front();
          compare_field("status", want.status, out_ch.status);
          compare_field("gps_week", want.week, out_ch.gps_week);
          compare_field("week_second_us", want.tow_us, out_ch.week_second_us);
        end
      end
      if (in_ch.valid && in_ch.ready)
        awaited_q.push_back(calendar_to_gps(in_ch.year, in_ch.month, in_ch.day,
                                            in_ch.hour, in_ch.minute, in_ch.second_us));
    end
    mismatches <= errors;
    awaited    <= awaited_q.size();
  end

endmodule

`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: calendar to GPS week/seconds core, top level
// Drives date/time beats into the core and drains its result beats with
// random gaps on both sides, a stretch with no gaps, and one long output
// hold-off. The checker beside the core does the prediction and comparing.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import c2gws_pkg::*;

  localparam int PERIOD_NS   = 12;
  localparam int SPAN        = 256;
  localparam int N_RANDOM    = 1250;
  localparam int IDLE_PCT    = 16;     // chance of an idle cycle on either side
  localparam int STEADY_LO   = 500;    // random beats in [STEADY_LO, STEADY_HI)
  localparam int STEADY_HI   = 800;    //   go with no idling on either side
  localparam int HOLD_AT     = 200;    // beats sent before the output hold-off
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 8;     // four-stage pipe, plus margin
  localparam int LIMIT_NS    = 5_000_000;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SEC_W-1:0]    second_us;
  } date_beat_t;

  logic clk;
  logic rst_n;

  c2gws_in_if  in_ch ();
  c2gws_out_if out_ch ();

  int mismatches;
  int awaited;

  // steady and beats_sent are shared between the sender and receiver processes
  bit steady    = 1'b0;
  bit held_off  = 1'b0;
  int beats_sent = 0;

  calendar_to_gps_week_seconds_core #(
    .YEAR_SPAN (SPAN)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gps_week_checker #(
    .YEAR_SPAN (SPAN)
  ) gps_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  initial clk = 1'b0;
  always #(PERIOD_NS / 2) clk = ~clk;

  function automatic date_beat_t on_date(input int y, input int mo, input int d,
                                         input int h, input int mi, input int s_us);
    date_beat_t r;
    r.year      = YEAR_W'(y);
    r.month     = MONTH_W'(mo);
    r.day       = DAY_W'(d);
    r.hour      = HOUR_W'(h);
    r.minute    = MINUTE_W'(mi);
    r.second_us = SEC_W'(s_us);
    return r;
  endfunction

  // Mostly legal dates inside the span with random content; some beats sit
  // on the edges of the span, and some are raw noise on every bit.
  function automatic date_beat_t random_date();
    date_beat_t  r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      r.year      = YEAR_W'($urandom);
      r.month     = MONTH_W'($urandom);
      r.day       = DAY_W'($urandom);
      r.hour      = HOUR_W'($urandom);
      r.minute    = MINUTE_W'($urandom);
      r.second_us = SEC_W'($urandom);
    end else if (pick < 22) begin
      // around 1980 / the top of the span: epoch and range edges
      r = on_date($urandom_range(0, 1) ? 1979 + $urandom_range(0, 2)
                                       : EPOCH_YEAR + SPAN - 2 + $urandom_range(0, 2),
                  $urandom_range(0, 13), $urandom_range(0, 31),
                  $urandom_range(0, 23), $urandom_range(0, 59),
                  $urandom_range(0, 60_999_999));
    end else begin
      r = on_date($urandom_range(EPOCH_YEAR, EPOCH_YEAR + SPAN - 1),
                  $urandom_range(1, 12), $urandom_range(1, 31),
                  $urandom_range(0, 23), $urandom_range(0, 59),
                  $urandom_range(0, 60_999_999));
    end
    return r;
  endfunction

  // Offer one date beat and wait until the core takes it. Idle cycles go in
  // before the beat; with none, valid simply stays high for the next beat.
  task automatic send_date(input date_beat_t d);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid     <= 1'b1;
    in_ch.year      <= d.year;
    in_ch.month     <= d.month;
    in_ch.day       <= d.day;
    in_ch.hour      <= d.hour;
    in_ch.minute    <= d.minute;
    in_ch.second_us <= d.second_us;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  // Receiver: random stalls, none in the steady stretch, and one long
  // hold-off once traffic is flowing so the pipe fills and backs up.
  initial begin : drain
    int held;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && beats_sent >= HOLD_AT) begin
        out_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        held_off = 1'b1;
      end
      out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin : stimulus
    date_beat_t directed_q[$];
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.year      <= '0;
    in_ch.month     <= '0;
    in_ch.day       <= '0;
    in_ch.hour      <= '0;
    in_ch.minute    <= '0;
    in_ch.second_us <= '0;

    directed_q = '{
      on_date(1980,  1,  6,  0,  0, 0),              // epoch itself
      on_date(1980,  1,  5, 23, 59, 59_999_999),     // last instant before epoch
      on_date(1980,  1,  1,  0,  0, 0),              // start of 1980, pre-epoch
      on_date(1979, 12, 31, 12,  0, 0),              // year below span
      on_date(0,     0,  0,  0,  0, 0),              // all fields zero
      on_date(4095, 15, 31, 31, 63, 67_108_863),     // all fields at max
      on_date(SPAN + 1979, 12, 31, 31, 63, 67_108_863), // last year, largest sum
      on_date(SPAN + 1980,  1,  1,  0,  0, 0),       // first year past span
      on_date(2000,  0, 10,  1,  2, 3_000_000),      // month zero
      on_date(2000, 13, 10,  1,  2, 3_000_000),      // month past December
      on_date(2000,  5,  0,  1,  2, 3_000_000),      // day zero
      on_date(2000,  2, 31,  6, 30, 0),              // day beyond month length
      on_date(2000,  3,  1,  0,  0, 0),              // 400-year leap
      on_date(2100,  3,  1,  0,  0, 0),              // century, not leap
      on_date(2200,  3,  1,  0,  0, 0),
      on_date(2024,  2, 29, 18, 45, 12_345_678),
      on_date(1980,  3,  1,  0,  0, 0),              // epoch year is leap
      on_date(2016, 12, 31, 23, 59, 60_999_999),     // leap second
      on_date(1999,  8, 21, 23, 59, 59_999_999),     // end of week 1023
      on_date(1999,  8, 22,  0,  0, 0),              // week 1024
      on_date(2019,  4,  7,  0,  0, 0),              // week 2048
      on_date(1980,  1, 12, 23, 59, 59_999_999)      // last instant of week 0
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_q[k]) send_date(directed_q[k]);

    for (int i = 0; i < N_RANDOM; i++) begin
      steady = (i >= STEADY_LO) && (i < STEADY_HI);
      send_date(random_date());
    end
    steady = 1'b0;

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    // let any stray beat still in the pipe show up
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && awaited == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
